// ===== sv/ale_pkg.sv =====
// ale_pkg: shared constants, operation and status codes, and the types
// passed between the list cells, the match groups and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = 6;
   localparam int WORD_W  = 8;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;
   localparam int FUNC_W  = 3;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WIDE_W  = CNT_W + IDX_W;
   localparam int GRP_N   = 8;
   localparam int OFS_W   = $clog2(GRP_N);
   localparam int NGRP    = (DEPTH + GRP_N - 1) / GRP_N;
   localparam int NPAD    = NGRP * GRP_N;

   localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_SET    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_FIND   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              write;
      logic              get;
      logic              find;
      logic [WIDE_W-1:0] pivot;
      logic [WIDE_W-1:0] wr_pos;
      logic [WIDE_W-1:0] fill;
      logic [WORD_W-1:0] value;
   } cmd_type;

   // lowest hit within one group of cells
   typedef struct packed {
      logic              found;
      logic [OFS_W-1:0]  offset;
      logic [WORD_W-1:0] data;
   } grp_type;

endpackage

`default_nettype wire

// ===== sv/array_list_engine.sv =====
// array_list_engine: bounded ordered list of bytes, top level.
// Depends on ale_pkg, ale_cell, ale_group.
//
// Every command passes from acceptance to its result word through the
// cells, which shift or load at the accepting edge and flag their hits,
// the group priority stage, which registers the lowest hit of each eight
// cells, and the final stage, which combines the groups into the registered
// result. busy rises at the accepting edge and falls as the result strobe
// is shown, when a new command may be accepted. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ale_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [ale_pkg::IDX_W-1:0]     req_index,
   input  wire logic [ale_pkg::WORD_W-1:0]    req_value,
   output logic                               rsp_strobe,
   output logic      [ale_pkg::STAT_W-1:0]    rsp_status,
   output logic      [ale_pkg::WORD_W-1:0]    rsp_data,
   output logic      [ale_pkg::IDX_W-1:0]     rsp_position,
   output logic      [ale_pkg::COUNT_W-1:0]   rsp_count
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_GROUP = 3'b010,
      S_REPLY = 3'b100
   } state_type;

   state_type                                   state_ff, state_in;
   logic [ale_pkg::CNT_W-1:0]                   fill_ff, fill_in;
   logic [ale_pkg::STAT_W-1:0]                  status_ff, status_in;
   logic                                        find_ff, find_in;
   logic                                        get_ff, get_in;
   ale_pkg::grp_type                            grp_ff [ale_pkg::NGRP];
   ale_pkg::grp_type                            grp_in [ale_pkg::NGRP];
   logic                                        strobe_ff, strobe_in;
   logic [ale_pkg::STAT_W-1:0]                  rsp_status_ff, rsp_status_in;
   logic [ale_pkg::WORD_W-1:0]                  rsp_data_ff, rsp_data_in;
   logic [ale_pkg::IDX_W-1:0]                   rsp_position_ff, rsp_position_in;
   logic [ale_pkg::COUNT_W-1:0]                 rsp_count_ff, rsp_count_in;

   ale_pkg::cmd_type                            cmd;
   logic                                        accept;
   logic [ale_pkg::WIDE_W-1:0]                  idx_w, fill_w;
   logic                                        full, idx_in_list, idx_le_fill;

   logic [ale_pkg::DEPTH-1:0][ale_pkg::WORD_W-1:0] cell_data, left_data, right_data;
   logic [ale_pkg::DEPTH-1:0]                   cell_hit;
   logic [ale_pkg::NPAD-1:0][ale_pkg::WORD_W-1:0]  data_pad;
   logic [ale_pkg::NPAD-1:0]                    hit_pad;

   logic                                        found;
   logic [ale_pkg::WIDE_W-1:0]                  found_pos, wide_count;
   logic [ale_pkg::WORD_W-1:0]                  found_data;

   assign accept      = start && (state_ff == S_IDLE);
   assign busy        = (state_ff != S_IDLE);
   assign idx_w       = ale_pkg::WIDE_W'(req_index);
   assign fill_w      = ale_pkg::WIDE_W'(fill_ff);
   assign full        = (fill_ff == ale_pkg::CNT_W'(ale_pkg::DEPTH));
   assign idx_in_list = (idx_w < fill_w);
   assign idx_le_fill = (idx_w <= fill_w);

   // command decode
   always_comb begin
      cmd        = '0;
      cmd.pivot  = idx_w;
      cmd.wr_pos = idx_w;
      cmd.fill   = fill_w;
      cmd.value  = req_value;
      fill_in    = fill_ff;
      status_in  = status_ff;
      find_in    = find_ff;
      get_in     = get_ff;
      if (accept) begin
         status_in = ale_pkg::ST_OK;
         find_in   = 1'b0;
         get_in    = 1'b0;
         unique case (req_func)
            ale_pkg::FN_APPEND: begin
               if (full) begin
                  status_in = ale_pkg::ST_FULL;
               end else begin
                  cmd.write  = 1'b1;
                  cmd.wr_pos = fill_w;
                  fill_in    = fill_ff + ale_pkg::CNT_W'(1);
               end
            end
            ale_pkg::FN_INSERT: begin
               if (!idx_le_fill) begin
                  status_in = ale_pkg::ST_BAD_INDEX;
               end else if (full) begin
                  status_in = ale_pkg::ST_FULL;
               end else begin
                  cmd.shift_up = 1'b1;
                  fill_in      = fill_ff + ale_pkg::CNT_W'(1);
               end
            end
            ale_pkg::FN_DELETE: begin
               if (!idx_in_list) begin
                  status_in = ale_pkg::ST_BAD_INDEX;
               end else begin
                  cmd.shift_down = 1'b1;
                  fill_in        = fill_ff - ale_pkg::CNT_W'(1);
               end
            end
            ale_pkg::FN_GET: begin
               if (!idx_in_list) begin
                  status_in = ale_pkg::ST_BAD_INDEX;
               end else begin
                  cmd.get = 1'b1;
                  get_in  = 1'b1;
               end
            end
            ale_pkg::FN_SET: begin
               if (!idx_in_list) begin
                  status_in = ale_pkg::ST_BAD_INDEX;
               end else begin
                  cmd.write = 1'b1;
               end
            end
            ale_pkg::FN_FIND: begin
               cmd.find = 1'b1;
               find_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // cell row
   for (genvar k = 0; k < ale_pkg::DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
         assign left_data[k] = '0;
      end else begin : g_mid_l
         assign left_data[k] = cell_data[k-1];
      end
      if (k == ale_pkg::DEPTH - 1) begin : g_last
         assign right_data[k] = cell_data[k];
      end else begin : g_mid_r
         assign right_data[k] = cell_data[k+1];
      end

      ale_cell u_cell (
         .clock      (clock),
         .pos        (ale_pkg::WIDE_W'(k)),
         .cmd        (cmd),
         .left_data  (left_data[k]),
         .right_data (right_data[k]),
         .data_ff    (cell_data[k]),
         .hit_ff     (cell_hit[k])
      );
   end

   for (genvar k = 0; k < ale_pkg::NPAD; k++) begin : g_pad
      if (k < ale_pkg::DEPTH) begin : g_real
         assign hit_pad[k]  = cell_hit[k];
         assign data_pad[k] = cell_data[k];
      end else begin : g_fill
         assign hit_pad[k]  = 1'b0;
         assign data_pad[k] = '0;
      end
   end

   for (genvar g = 0; g < ale_pkg::NGRP; g++) begin : g_grp
      ale_group u_group (
         .hits   (hit_pad[g*ale_pkg::GRP_N +: ale_pkg::GRP_N]),
         .data   (data_pad[g*ale_pkg::GRP_N +: ale_pkg::GRP_N]),
         .result (grp_in[g])
      );
   end

   // final priority over groups
   always_comb begin
      found      = 1'b0;
      found_pos  = '0;
      found_data = '0;
      for (int g = ale_pkg::NGRP - 1; g >= 0; g--) begin
         if (grp_ff[g].found) begin
            found      = 1'b1;
            found_pos  = ale_pkg::WIDE_W'(g * ale_pkg::GRP_N) +
                         ale_pkg::WIDE_W'(grp_ff[g].offset);
            found_data = grp_ff[g].data;
         end
      end
   end

   assign wide_count = ale_pkg::WIDE_W'(fill_ff);

   always_comb begin
      state_in        = state_ff;
      strobe_in       = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_GROUP;
            end
         end
         S_GROUP: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            state_in        = S_IDLE;
            strobe_in       = 1'b1;
            rsp_count_in    = wide_count[ale_pkg::COUNT_W-1:0];
            rsp_data_in     = '0;
            rsp_position_in = '0;
            rsp_status_in   = status_ff;
            if (find_ff) begin
               if (found) begin
                  rsp_status_in   = ale_pkg::ST_OK;
                  rsp_position_in = found_pos[ale_pkg::IDX_W-1:0];
               end else begin
                  rsp_status_in = ale_pkg::ST_NOT_FOUND;
               end
            end else if (get_ff) begin
               rsp_data_in = found_data;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      find_ff         <= find_in;
      get_ff          <= get_in;
      grp_ff          <= grp_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== sv/ale_cell.sv =====
// ale_cell: one list entry. Holds a word, takes a neighbor's word on a
// shift, loads on a write, and registers a hit flag for get and find.
// Depends on ale_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ale_cell (
   input  wire logic                         clock,
   input  wire logic [ale_pkg::WIDE_W-1:0]   pos,
   input  wire ale_pkg::cmd_type             cmd,
   input  wire logic [ale_pkg::WORD_W-1:0]   left_data,
   input  wire logic [ale_pkg::WORD_W-1:0]   right_data,
   output logic      [ale_pkg::WORD_W-1:0]   data_ff,
   output logic                              hit_ff
);

   logic [ale_pkg::WORD_W-1:0] data_in;
   logic                       hit_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (pos > cmd.pivot) begin
            data_in = left_data;
         end else if (pos == cmd.pivot) begin
            data_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (pos >= cmd.pivot) begin
            data_in = right_data;
         end
      end else if (cmd.write && (pos == cmd.wr_pos)) begin
         data_in = cmd.value;
      end
   end

   assign hit_in = (cmd.get && (pos == cmd.pivot)) ||
                   (cmd.find && (pos < cmd.fill) && (data_ff == cmd.value));

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

endmodule

`default_nettype wire

// ===== sv/ale_group.sv =====
// ale_group: picks the lowest hit among one group of cells and its word.
// Depends on ale_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ale_group (
   input  wire logic [ale_pkg::GRP_N-1:0]                     hits,
   input  wire logic [ale_pkg::GRP_N-1:0][ale_pkg::WORD_W-1:0] data,
   output ale_pkg::grp_type                                   result
);

   always_comb begin
      result = '0;
      for (int i = ale_pkg::GRP_N - 1; i >= 0; i--) begin
         if (hits[i]) begin
            result.found  = 1'b1;
            result.offset = ale_pkg::OFS_W'(i);
            result.data   = data[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ale_checker.sv =====
// ale_checker: port-level checks on the command/result timing and the
// find-miss payload of array_list_engine, bound to the top level. Depends on ale_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ale_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_strobe,
   input wire logic [ale_pkg::STAT_W-1:0]    rsp_status,
   input wire logic [ale_pkg::WORD_W-1:0]    rsp_data,
   input wire logic [ale_pkg::IDX_W-1:0]     rsp_position
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_reply_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result word missing three cycles after accept");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held over two cycles");

   a_idle_on_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while result word shown");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ale_pkg::ST_NOT_FOUND)) |->
         ((rsp_position == '0) && (rsp_data == '0)))
      else $error("find miss with nonzero payload");

endmodule

bind array_list_engine ale_checker u_ale_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_data     (rsp_data),
   .rsp_position (rsp_position)
);

`default_nettype wire

// ===== tb/tb_array_list_engine.sv =====
// tb_array_list_engine: self-checking testbench for the array_list_engine list block.
// Depends on ale_pkg and array_list_engine; keeps its own list model to predict each word.
// Runs directed, full-list and random command streams; each result word is checked field by field.
`timescale 1ns / 1ps

module tb_array_list_engine;

   import ale_pkg::*;

   // unused operation codes, expected to be ignored
   localparam logic [FUNC_W-1:0] FN_RSVD_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_RSVD_HI = 3'd7;

   localparam int QUIET_LIMIT = 1000;
   localparam int TAIL_CYCLES = 6;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [WORD_W-1:0]  data;
      logic [IDX_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic [FUNC_W-1:0]   req_func  = '0;
   logic [IDX_W-1:0]    req_index = '0;
   logic [WORD_W-1:0]   req_value = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [WORD_W-1:0]   rsp_data;
   logic [IDX_W-1:0]    rsp_position;
   logic [COUNT_W-1:0]  rsp_count;

   logic [WORD_W-1:0]   list_cells [DEPTH];
   int                  list_fill = 0;
   list_result_type     pending_results [$];
   int                  mismatches = 0;
   int                  sender_idle_pct = 0;
   int                  quiet_cycles = 0;

   array_list_engine u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_index    (req_index),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // list model: applies one command, returns the word it should produce
   function automatic list_result_type apply_command(input logic [FUNC_W-1:0] f,
                                                     input logic [IDX_W-1:0]  idx,
                                                     input logic [WORD_W-1:0] v);
      list_result_type r;
      int              k;
      int              pos;
      bit              hit;
      r        = '0;
      r.status = ST_OK;
      hit      = 1'b0;
      pos      = int'(idx);
      case (f)
         FN_APPEND: begin
            if (list_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_cells[IDX_W'(list_fill)] = v;
               list_fill++;
            end
         end
         FN_INSERT: begin
            if (pos > list_fill) begin
               r.status = ST_BAD_INDEX;
            end else if (list_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (k = list_fill; k > pos; k--)
                  list_cells[IDX_W'(k)] = list_cells[IDX_W'(k-1)];
               list_cells[IDX_W'(pos)] = v;
               list_fill++;
            end
         end
         FN_DELETE: begin
            if (pos >= list_fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (k = pos; k + 1 < list_fill; k++)
                  list_cells[IDX_W'(k)] = list_cells[IDX_W'(k+1)];
               list_fill--;
            end
         end
         FN_GET: begin
            if (pos >= list_fill)
               r.status = ST_BAD_INDEX;
            else
               r.data = list_cells[IDX_W'(pos)];
         end
         FN_SET: begin
            if (pos >= list_fill)
               r.status = ST_BAD_INDEX;
            else
               list_cells[IDX_W'(pos)] = v;
         end
         FN_FIND: begin
            r.status = ST_NOT_FOUND;
            for (k = 0; k < list_fill; k++) begin
               if (!hit && list_cells[IDX_W'(k)] == v) begin
                  hit        = 1'b1;
                  r.status   = ST_OK;
                  r.position = IDX_W'(k);
               end
            end
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(list_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: %s mismatch, got %0d, want %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   // one command word; start stays high on return so back-to-back words need no gap
   task automatic send_word(input logic [FUNC_W-1:0] f,
                            input logic [IDX_W-1:0]  idx,
                            input logic [WORD_W-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= f;
      req_index <= idx;
      req_value <= v;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_command(f, idx, v));
   endtask

   task automatic drain_results;
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_directed;
      send_word(FN_GET,    6'd0,  8'h00);   // empty list: bad index
      send_word(FN_DELETE, 6'd0,  8'h00);
      send_word(FN_SET,    6'd0,  8'h11);
      send_word(FN_FIND,   6'd0,  8'h00);   // miss on empty list
      send_word(FN_INSERT, 6'd1,  8'h22);   // past the end
      send_word(FN_INSERT, 6'd0,  8'hFF);
      send_word(FN_APPEND, 6'd0,  8'h00);
      send_word(FN_APPEND, 6'd0,  8'hA5);
      send_word(FN_INSERT, 6'd3,  8'h5A);   // index equal to length
      send_word(FN_INSERT, 6'd1,  8'hA5);
      send_word(FN_FIND,   6'd0,  8'hA5);   // lowest of two hits
      send_word(FN_GET,    6'd4,  8'h00);
      send_word(FN_GET,    6'd5,  8'h00);
      send_word(FN_SET,    6'd63, 8'h01);
      send_word(FN_GET,    6'd63, 8'h00);
      send_word(FN_INSERT, 6'd63, 8'h02);
      send_word(FN_DELETE, 6'd63, 8'h00);
      send_word(FN_SET,    6'd2,  8'h3C);
      send_word(FN_DELETE, 6'd0,  8'h00);
      send_word(FN_DELETE, 6'd3,  8'h00);   // last entry
      send_word(FN_FIND,   6'd0,  8'hFF);
      send_word(FN_RSVD_LO, 6'd63, 8'hFF);
      send_word(FN_RSVD_HI, 6'd0,  8'h00);
      send_word(FN_GET,    6'd0,  8'h00);
      drain_results();
   endtask

   task automatic test_full_list;
      while (list_fill > 0)
         send_word(FN_DELETE, 6'd0, 8'h00);
      while (list_fill < DEPTH)
         send_word(FN_APPEND, IDX_W'($urandom_range(63)), WORD_W'(list_fill));
      send_word(FN_APPEND, 6'd0,  8'h77);
      send_word(FN_INSERT, 6'd0,  8'h77);
      send_word(FN_INSERT, 6'd63, 8'h77);
      send_word(FN_GET,    6'd63, 8'h00);
      send_word(FN_FIND,   6'd0,  8'd63);   // hit in the top cell
      send_word(FN_FIND,   6'd0,  8'd200);
      send_word(FN_SET,    6'd63, 8'hFF);
      send_word(FN_DELETE, 6'd63, 8'h00);
      send_word(FN_INSERT, 6'd63, 8'h80);
      send_word(FN_DELETE, 6'd0,  8'h00);
      drain_results();
   endtask

   task automatic test_random(input int items, input int idle_pct);
      int                n;
      int                roll;
      int                top;
      logic [FUNC_W-1:0] f;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] v;
      sender_idle_pct = idle_pct;
      for (n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         if (roll < 18)      f = FN_APPEND;
         else if (roll < 36) f = FN_INSERT;
         else if (roll < 58) f = FN_DELETE;
         else if (roll < 70) f = FN_GET;
         else if (roll < 80) f = FN_SET;
         else if (roll < 96) f = FN_FIND;
         else                f = roll[0] ? FN_RSVD_HI : FN_RSVD_LO;
         // alternate growing and shrinking stretches
         if (((n / 150) % 2) == 1 && (f == FN_APPEND || f == FN_INSERT)
             && $urandom_range(1) == 1)
            f = FN_DELETE;
         if (list_fill <= 2 && f == FN_DELETE && $urandom_range(1) == 1)
            f = FN_APPEND;
         top = (f == FN_INSERT) ? list_fill : list_fill - 1;
         if (top > 63)
            top = 63;
         if (top >= 0 && $urandom_range(99) < 85)
            idx = IDX_W'($urandom_range(top));
         else
            idx = IDX_W'($urandom_range(63));
         v = ($urandom_range(1) == 1) ? WORD_W'($urandom_range(7))
                                      : WORD_W'($urandom_range(255));
         if (f == FN_FIND && list_fill > 0 && $urandom_range(99) < 60)
            v = list_cells[IDX_W'($urandom_range(list_fill - 1))];
         send_word(f, idx, v);
         if (n % 250 == 249)
            drain_results();
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_data !== want.data)
               report_mismatch("data", int'(rsp_data), int'(want.data));
            if (rsp_position !== want.position)
               report_mismatch("position", int'(rsp_position), int'(want.position));
            if (rsp_count !== want.count)
               report_mismatch("count", int'(rsp_count), int'(want.count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("array_list_engine verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 12;
      test_directed();
      test_full_list();
      test_random(660, 12);
      test_random(660, 61);
      test_random(660, 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("array_list_engine verification clean");
      else
         $display("array_list_engine verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ale_pkg.sv
sv/ale_cell.sv
sv/ale_group.sv
sv/array_list_engine.sv
sv/ale_checker.sv
tb/tb_array_list_engine.sv
